>>> hw/rtl/bvva_pkg.sv
// ---------------------------------------------------------------------------
// Bandwidth and voltage vote aggregator package
// Shared widths, codes and types for the vote aggregator block.
// ---------------------------------------------------------------------------
package bvva_pkg;

	localparam int NUM_RES = 32;

	localparam int IDX_W  = 5;
	localparam int BW_W   = 20;
	localparam int VOLT_W = 3;
	localparam int TBW_W  = 25;
	localparam int MASK_W = 32;

	// Partial sums grow by one bit for each doubling of the cell count.
	localparam int SUM_W  = BW_W + $clog2(NUM_RES);
	localparam int WIDE_W = (SUM_W > TBW_W) ? SUM_W : TBW_W;
	// Wide enough to hold both any event index and any cell number.
	localparam int CMP_W  = IDX_W + $clog2(NUM_RES);
	localparam int CNT_W  = $clog2(NUM_RES);

	localparam logic [TBW_W-1:0]  TBW_MAX    = {TBW_W{1'b1}};
	localparam logic [MASK_W-1:0] MASK_RESET = 32'h5555_5555;

	localparam logic ST_OK      = 1'b0;
	localparam logic ST_MISSING = 1'b1;

	typedef enum logic [1:0] {
		RS_RELEASED   = 2'd0,
		RS_REQUESTING = 2'd1,
		RS_GRANTED    = 2'd2,
		RS_RELEASING  = 2'd3
	} bvva_rstate_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_RUN,
		FSM_DONE
	} bvva_fsm_t;

	// Running aggregate handed from one cell to the next.
	typedef struct packed {
		logic [SUM_W-1:0]  prod;
		logic [SUM_W-1:0]  cons;
		logic [VOLT_W-1:0] vmax;
	} bvva_part_t;

	// Sequencer outputs toward the datapath.
	typedef struct packed {
		logic in_ready;
		logic finish;
		logic miss;
	} bvva_ctl_t;

endpackage

>>> hw/rtl/bvva_ifs.sv
// ---------------------------------------------------------------------------
// Bandwidth and voltage vote aggregator channels
// Valid/ready channel interfaces for events, results and configuration.
// ---------------------------------------------------------------------------
interface bvva_event_if;
	logic                        valid;
	logic                        ready;
	logic [bvva_pkg::IDX_W-1:0]  resource_index;
	logic                        resource_present;
	logic [1:0]                  resource_state;
	logic [bvva_pkg::BW_W-1:0]   max_bandwidth;
	logic [bvva_pkg::BW_W-1:0]   needed_bandwidth;
	logic [bvva_pkg::VOLT_W-1:0] floor_level;

	modport source (
		output valid, resource_index, resource_present, resource_state,
		       max_bandwidth, needed_bandwidth, floor_level,
		input  ready
	);
	modport sink (
		input  valid, resource_index, resource_present, resource_state,
		       max_bandwidth, needed_bandwidth, floor_level,
		output ready
	);
endinterface

interface bvva_result_if;
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic                        vote_changed;
	logic [bvva_pkg::VOLT_W-1:0] total_voltage;
	logic [bvva_pkg::TBW_W-1:0]  total_bandwidth;

	modport source (
		output valid, status, vote_changed, total_voltage, total_bandwidth,
		input  ready
	);
	modport sink (
		input  valid, status, vote_changed, total_voltage, total_bandwidth,
		output ready
	);
endinterface

interface bvva_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [bvva_pkg::MASK_W-1:0] data;

	modport source (
		output valid, data,
		input  ready
	);
	modport sink (
		input  valid, data,
		output ready
	);
endinterface

>>> hw/rtl/bvva_cell.sv
// ---------------------------------------------------------------------------
// Vote cell
// Holds one resource's votes and adds them into the running aggregate.
// ---------------------------------------------------------------------------
module bvva_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [bvva_pkg::BW_W-1:0]   wr_bw,
	input  logic [bvva_pkg::VOLT_W-1:0] wr_volt,
	input  logic                        is_prod,
	input  bvva_pkg::bvva_part_t        part_in,
	output bvva_pkg::bvva_part_t        part_out
);

	logic [bvva_pkg::BW_W-1:0]   bw_q;
	logic [bvva_pkg::VOLT_W-1:0] volt_q;
	bvva_pkg::bvva_part_t        part_q;
	bvva_pkg::bvva_part_t        part_d;
	logic [bvva_pkg::SUM_W-1:0]  bw_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q   <= '0;
			volt_q <= '0;
		end else if (wr_en) begin
			bw_q   <= wr_bw;
			volt_q <= wr_volt;
		end
	end

	always_comb begin
		bw_ext      = bvva_pkg::SUM_W'(bw_q);
		part_d.prod = is_prod ? part_in.prod + bw_ext : part_in.prod;
		part_d.cons = is_prod ? part_in.cons : part_in.cons + bw_ext;
		part_d.vmax = (volt_q > part_in.vmax) ? volt_q : part_in.vmax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
		end else begin
			part_q <= part_d;
		end
	end

	assign part_out = part_q;

endmodule

>>> hw/rtl/bvva_ctrl.sv
// ---------------------------------------------------------------------------
// Event sequencer
// Accepts one event, waits for the cell row to settle unless the resource is missing, then hands off.
// ---------------------------------------------------------------------------
module bvva_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                miss_in,
	input  logic                out_free,
	output bvva_pkg::bvva_ctl_t ctl
);

	bvva_pkg::bvva_fsm_t        state_q, state_d;
	logic [bvva_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic                       miss_q, miss_d;
	logic                       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bvva_pkg::FSM_IDLE;
			cnt_q   <= '0;
			miss_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			miss_q  <= miss_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		miss_d       = miss_q;
		ctl.in_ready = 1'b0;
		ctl.finish   = 1'b0;
		ctl.miss     = miss_q;
		accept       = 1'b0;
		case (state_q)
			bvva_pkg::FSM_IDLE: begin
				ctl.in_ready = 1'b1;
				accept       = in_valid;
				if (accept) begin
					miss_d  = miss_in;
					cnt_d   = '0;
					// A missing resource changes nothing, so no settling is needed.
					state_d = miss_in ? bvva_pkg::FSM_DONE : bvva_pkg::FSM_RUN;
				end
			end
			bvva_pkg::FSM_RUN: begin
				if (cnt_q == bvva_pkg::CNT_W'(bvva_pkg::NUM_RES - 1)) begin
					state_d = bvva_pkg::FSM_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			bvva_pkg::FSM_DONE: begin
				if (out_free) begin
					ctl.finish = 1'b1;
					state_d    = bvva_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = bvva_pkg::FSM_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/bandwidth_voltage_vote_aggregator.sv
// ---------------------------------------------------------------------------
// Bandwidth and voltage vote aggregator
// Per-resource vote store with running producer/consumer and voltage totals.
// ---------------------------------------------------------------------------
// Each event transfer updates one resource's bandwidth and voltage votes and
// returns one result transfer with the aggregate voltage (largest vote), the
// aggregate bandwidth (lesser of the producer and consumer sums, producers
// chosen by the producer mask), a changed flag and a status. The votes live in
// a row of NUM_RES cells; every cell adds its own votes to the running totals
// it receives from its left neighbor and registers the result, so the totals
// for a new vote reach the end of the row through the registers of the cells.
// An event for a present resource therefore waits in the settling state while
// the totals pass down the cell row, then in the hand-off state until the
// output register is free; an event for a missing resource skips the settling.
// A new event is taken while the previous result still waits in the output
// register. The producer mask is written through the configuration channel,
// which is always ready, and is picked up by the next event; it must only be
// written while no event is in flight. All votes reset to zero.
// ---------------------------------------------------------------------------
module bandwidth_voltage_vote_aggregator (
	input  logic                  clk,
	input  logic                  arst_n,
	bvva_cfg_if.sink              cfg,
	bvva_event_if.sink            req,
	bvva_result_if.source         rsp
);

	// Configuration register.
	logic [bvva_pkg::MASK_W-1:0] mask_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= bvva_pkg::MASK_RESET;
		end else if (cfg.valid) begin
			mask_q <= cfg.data;
		end
	end

	// Event decode: range check and the new vote, computed once for all cells.
	logic [bvva_pkg::CMP_W-1:0]  idx_ext;
	logic                        miss_now;
	logic                        active;
	logic [bvva_pkg::BW_W-1:0]   new_bw;
	logic [bvva_pkg::VOLT_W-1:0] new_volt;
	logic                        wr_go;

	always_comb begin
		idx_ext  = bvva_pkg::CMP_W'(req.resource_index);
		miss_now = !req.resource_present ||
		           (idx_ext >= bvva_pkg::CMP_W'(bvva_pkg::NUM_RES));
		active   = req.resource_state inside {bvva_pkg::RS_REQUESTING,
		                                      bvva_pkg::RS_GRANTED};
		if (active) begin
			new_bw   = (req.max_bandwidth < req.needed_bandwidth) ?
			           req.max_bandwidth : req.needed_bandwidth;
			new_volt = req.floor_level;
		end else begin
			new_bw   = '0;
			new_volt = '0;
		end
	end

	// Sequencer.
	bvva_pkg::bvva_ctl_t ctl;
	logic                rsp_valid_q;
	logic                out_free;

	assign out_free = !rsp_valid_q || rsp.ready;

	bvva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.miss_in  (miss_now),
		.out_free (out_free),
		.ctl      (ctl)
	);

	assign req.ready = ctl.in_ready;
	// The vote is written at the same edge as the event transfer.
	assign wr_go     = req.valid && ctl.in_ready && !miss_now;

	// Row of vote cells; cell 0 starts from empty totals.
	bvva_pkg::bvva_part_t part [bvva_pkg::NUM_RES+1];

	assign part[0] = '0;

	for (genvar i = 0; i < bvva_pkg::NUM_RES; i++) begin : g_cell
		logic is_prod;
		logic wr_en;

		// Resources beyond the width of the mask always count as consumers.
		if (i < bvva_pkg::MASK_W) begin : g_mask
			assign is_prod = mask_q[i];
		end else begin : g_nomask
			assign is_prod = 1'b0;
		end

		assign wr_en = wr_go && (idx_ext == bvva_pkg::CMP_W'(i));

		bvva_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en),
			.wr_bw    (new_bw),
			.wr_volt  (new_volt),
			.is_prod  (is_prod),
			.part_in  (part[i]),
			.part_out (part[i+1])
		);
	end

	// Aggregate at the end of the row, saturated to the result width.
	bvva_pkg::bvva_part_t        tail;
	logic [bvva_pkg::SUM_W-1:0]  least;
	logic [bvva_pkg::WIDE_W-1:0] least_w;
	logic [bvva_pkg::TBW_W-1:0]  agg_bw;

	always_comb begin
		tail    = part[bvva_pkg::NUM_RES];
		least   = (tail.prod < tail.cons) ? tail.prod : tail.cons;
		least_w = bvva_pkg::WIDE_W'(least);
		if (least_w > bvva_pkg::WIDE_W'(bvva_pkg::TBW_MAX)) begin
			agg_bw = bvva_pkg::TBW_MAX;
		end else begin
			agg_bw = bvva_pkg::TBW_W'(least_w);
		end
	end

	// Current aggregates and the output register.
	logic [bvva_pkg::VOLT_W-1:0] cur_volt_q;
	logic [bvva_pkg::TBW_W-1:0]  cur_bw_q;
	logic                        status_q;
	logic                        changed_q;
	logic [bvva_pkg::VOLT_W-1:0] tot_volt_q;
	logic [bvva_pkg::TBW_W-1:0]  tot_bw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_volt_q  <= '0;
			cur_bw_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.finish) begin
				rsp_valid_q <= 1'b1;
				if (!ctl.miss) begin
					cur_volt_q <= tail.vmax;
					cur_bw_q   <= agg_bw;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			if (ctl.miss) begin
				status_q   <= bvva_pkg::ST_MISSING;
				changed_q  <= 1'b0;
				tot_volt_q <= cur_volt_q;
				tot_bw_q   <= cur_bw_q;
			end else begin
				status_q   <= bvva_pkg::ST_OK;
				changed_q  <= (tail.vmax != cur_volt_q) || (agg_bw != cur_bw_q);
				tot_volt_q <= tail.vmax;
				tot_bw_q   <= agg_bw;
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.vote_changed    = changed_q;
	assign rsp.total_voltage   = tot_volt_q;
	assign rsp.total_bandwidth = tot_bw_q;

	// A result is only loaded when the output register can take it.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> out_free)
		else $error("result loaded over an untaken result");

	// An event transfer is followed by work: ready is low in the cycle after it.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second event taken while one is in flight");

	// A missing resource leaves the aggregates untouched.
	a_miss_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.finish && ctl.miss) |=> ($stable(cur_volt_q) && $stable(cur_bw_q)))
		else $error("aggregates changed on a missing resource");

	// A missing status never reports a change.
	a_miss_nochange: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == bvva_pkg::ST_MISSING)) |-> !rsp.vote_changed)
		else $error("change flagged on a missing resource");

endmodule

>>> tb/tb_bandwidth_voltage_vote_aggregator.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Vote aggregator testbench
// Drives resource state-change events into the aggregator, predicts every
// result with a local copy of the vote store and the producer mask, and
// checks each result transfer field by field, in order, mostly under random idling.
// ---------------------------------------------------------------------------
module tb_bandwidth_voltage_vote_aggregator;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 60;
	localparam int MAX_PRINTED    = 20;

	// One event as the sender presents it.
	typedef struct packed {
		logic [bvva_pkg::IDX_W-1:0]  res_idx;
		logic                        present;
		bvva_pkg::bvva_rstate_t      state;
		logic [bvva_pkg::BW_W-1:0]   max_bw;
		logic [bvva_pkg::BW_W-1:0]   need_bw;
		logic [bvva_pkg::VOLT_W-1:0] floor_v;
	} vote_event_t;

	// One result as the block returns it.
	typedef struct packed {
		logic                        status;
		logic                        changed;
		logic [bvva_pkg::VOLT_W-1:0] volt;
		logic [bvva_pkg::TBW_W-1:0]  bw;
	} vote_totals_t;

	logic clk;
	logic arst_n;

	bvva_event_if  ev_ch ();
	bvva_result_if res_ch ();
	bvva_cfg_if    cfg_ch ();

	bandwidth_voltage_vote_aggregator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (ev_ch),
		.rsp    (res_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Local copy of the vote store, the aggregates and the producer mask.
	// It is advanced once per accepted event, in transfer order, so the
	// queue of expected totals lines up with the block's results.
	logic [bvva_pkg::BW_W-1:0]   bw_vote   [bvva_pkg::NUM_RES];
	logic [bvva_pkg::VOLT_W-1:0] volt_vote [bvva_pkg::NUM_RES];
	logic [bvva_pkg::VOLT_W-1:0] agg_volt;
	logic [bvva_pkg::TBW_W-1:0]  agg_bw;
	logic [bvva_pkg::MASK_W-1:0] producer_bits;

	vote_totals_t pending_totals [$];

	// Idling controls, one for the sender and one for the receiver.
	bit sender_gaps;
	bit sink_stalls;

	int unsigned err_count;
	int unsigned printed_count;
	int unsigned events_sent;
	int unsigned results_checked;
	int unsigned missing_seen;
	int unsigned changed_seen;
	int unsigned mask_writes;
	int unsigned quiet_cycles;

	// Applies one event to the local store and returns the totals that the
	// block must report for it. A missing resource leaves everything as is.
	function automatic vote_totals_t apply_vote(input vote_event_t ev);
		vote_totals_t                t;
		logic [39:0]                 prod_sum;
		logic [39:0]                 cons_sum;
		logic [39:0]                 least;
		logic [bvva_pkg::VOLT_W-1:0] vmax;
		logic [bvva_pkg::VOLT_W-1:0] prev_volt;
		logic [bvva_pkg::TBW_W-1:0]  prev_bw;
		prev_volt = agg_volt;
		prev_bw   = agg_bw;
		if (!ev.present || int'(ev.res_idx) >= bvva_pkg::NUM_RES) begin
			t.status  = bvva_pkg::ST_MISSING;
			t.changed = 1'b0;
			t.volt    = agg_volt;
			t.bw      = agg_bw;
			return t;
		end
		if (ev.state == bvva_pkg::RS_REQUESTING || ev.state == bvva_pkg::RS_GRANTED) begin
			bw_vote[ev.res_idx]   = (ev.max_bw < ev.need_bw) ? ev.max_bw : ev.need_bw;
			volt_vote[ev.res_idx] = ev.floor_v;
		end else begin
			bw_vote[ev.res_idx]   = '0;
			volt_vote[ev.res_idx] = '0;
		end
		prod_sum = '0;
		cons_sum = '0;
		vmax     = '0;
		for (int i = 0; i < bvva_pkg::NUM_RES; i++) begin
			if (volt_vote[i] > vmax)
				vmax = volt_vote[i];
			// Indices past the mask width always count as consumers.
			if (i < bvva_pkg::MASK_W && producer_bits[i])
				prod_sum += bw_vote[i];
			else
				cons_sum += bw_vote[i];
		end
		least = (prod_sum < cons_sum) ? prod_sum : cons_sum;
		if (least > 40'(bvva_pkg::TBW_MAX))
			least = 40'(bvva_pkg::TBW_MAX);
		agg_volt  = vmax;
		agg_bw    = least[bvva_pkg::TBW_W-1:0];
		t.status  = bvva_pkg::ST_OK;
		t.changed = (agg_volt != prev_volt) || (agg_bw != prev_bw);
		t.volt    = agg_volt;
		t.bw      = agg_bw;
		return t;
	endfunction

	function automatic vote_event_t make_event(input int idx, input bit present,
			input bvva_pkg::bvva_rstate_t state, input int max_bw, input int need_bw,
			input int floor_v);
		vote_event_t ev;
		ev.res_idx = bvva_pkg::IDX_W'(idx);
		ev.present = present;
		ev.state   = state;
		ev.max_bw  = bvva_pkg::BW_W'(max_bw);
		ev.need_bw = bvva_pkg::BW_W'(need_bw);
		ev.floor_v = bvva_pkg::VOLT_W'(floor_v);
		return ev;
	endfunction

	// Bandwidths lean toward the extremes so that the sums get large.
	function automatic logic [bvva_pkg::BW_W-1:0] pick_bandwidth();
		case ($urandom_range(0, 7))
			0, 1: return '1;
			2: return '0;
			3: return bvva_pkg::BW_W'($urandom_range(0, 255));
			default: return bvva_pkg::BW_W'($urandom);
		endcase
	endfunction

	// Mostly present resources with active votes, so the store fills up;
	// releases and missing resources are mixed in.
	function automatic vote_event_t random_event();
		vote_event_t ev;
		int unsigned pick;
		pick       = $urandom_range(0, 9);
		ev.res_idx = bvva_pkg::IDX_W'($urandom);
		ev.present = ($urandom_range(0, 6) != 0);
		if (pick < 3)
			ev.state = bvva_pkg::RS_GRANTED;
		else if (pick < 6)
			ev.state = bvva_pkg::RS_REQUESTING;
		else if (pick < 8)
			ev.state = bvva_pkg::RS_RELEASING;
		else
			ev.state = bvva_pkg::RS_RELEASED;
		ev.max_bw  = pick_bandwidth();
		ev.need_bw = pick_bandwidth();
		ev.floor_v = bvva_pkg::VOLT_W'($urandom);
		return ev;
	endfunction

	task automatic report_mismatch(input string what, input longint got,
			input longint want);
		err_count++;
		if (printed_count < MAX_PRINTED) begin
			printed_count++;
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
				$time, what, got, want);
		end
	endtask

	// Presents one event and returns at the edge where it transfers. Valid is
	// left high, so a following event goes out back to back.
	task automatic send_event(input vote_event_t ev);
		ev_ch.valid            <= 1'b1;
		ev_ch.resource_index   <= ev.res_idx;
		ev_ch.resource_present <= ev.present;
		ev_ch.resource_state   <= ev.state;
		ev_ch.max_bandwidth    <= ev.max_bw;
		ev_ch.needed_bandwidth <= ev.need_bw;
		ev_ch.floor_level      <= ev.floor_v;
		do
			@(posedge clk);
		while (!(ev_ch.valid && ev_ch.ready));
		pending_totals.push_back(apply_vote(ev));
		events_sent++;
	endtask

	task automatic pause_sender(input int unsigned cycles);
		ev_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_pause();
		if (sender_gaps && $urandom_range(0, 3) == 0)
			pause_sender($urandom_range(1, 15));
	endtask

	task automatic wait_drained();
		ev_ch.valid <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
	endtask

	// The mask is only written with no event in flight.
	task automatic write_mask(input logic [bvva_pkg::MASK_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!(cfg_ch.valid && cfg_ch.ready));
		producer_bits = value;
		mask_writes++;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_random_events(input int unsigned count);
		repeat (count) begin
			send_event(random_event());
			maybe_pause();
		end
	endtask

	// Extremes of every field, each state, the missing-resource case, votes
	// capped by the maximum and by the need, and a repeat that changes nothing.
	task automatic test_directed_cases();
		vote_event_t list [$];
		list.push_back(make_event(0, 0, bvva_pkg::RS_GRANTED, 'hFFFFF, 'hFFFFF, 7));
		list.push_back(make_event(0, 1, bvva_pkg::RS_GRANTED, 'hFFFFF, 'hFFFFF, 7));
		list.push_back(make_event(1, 1, bvva_pkg::RS_REQUESTING, 'hFFFFF, 'h12345, 3));
		list.push_back(make_event(3, 1, bvva_pkg::RS_GRANTED, 'h00ABC, 'hFFFFF, 5));
		list.push_back(make_event(1, 1, bvva_pkg::RS_GRANTED, 'hFFFFF, 'h12345, 3));
		list.push_back(make_event(31, 1, bvva_pkg::RS_GRANTED, 0, 0, 0));
		list.push_back(make_event(30, 1, bvva_pkg::RS_GRANTED, 'hFFFFF, 'hFFFFF, 1));
		list.push_back(make_event(31, 1, bvva_pkg::RS_REQUESTING, 'hFFFFF, 'hFFFFF, 6));
		list.push_back(make_event(2, 1, bvva_pkg::RS_REQUESTING, 1, 2, 2));
		list.push_back(make_event(31, 0, bvva_pkg::RS_RELEASING, 'hFFFFF, 'hFFFFF, 7));
		list.push_back(make_event(0, 1, bvva_pkg::RS_RELEASING, 'hFFFFF, 'hFFFFF, 7));
		list.push_back(make_event(30, 1, bvva_pkg::RS_RELEASED, 'hFFFFF, 'hFFFFF, 7));
		list.push_back(make_event(31, 1, bvva_pkg::RS_RELEASED, 0, 0, 0));
		list.push_back(make_event(2, 0, bvva_pkg::RS_RELEASED, 0, 0, 0));
		list.push_back(make_event(3, 1, bvva_pkg::RS_RELEASING, 0, 0, 0));
		list.push_back(make_event(1, 1, bvva_pkg::RS_RELEASED, 'h55555, 'hAAAAA, 5));
		list.push_back(make_event(2, 1, bvva_pkg::RS_RELEASED, 0, 0, 0));
		list.push_back(make_event(16, 1, bvva_pkg::RS_GRANTED, 'hAAAAA, 'h55555, 4));
		list.push_back(make_event(17, 1, bvva_pkg::RS_GRANTED, 'h55555, 'hAAAAA, 2));
		foreach (list[i]) begin
			send_event(list[i]);
			maybe_pause();
		end
	endtask

	// Several producer masks, the all-consumer and all-producer ones among
	// them, each followed by a batch of random events.
	task automatic test_mask_sweep();
		logic [bvva_pkg::MASK_W-1:0] masks [6];
		masks = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h0000_FFFF,
			32'h8000_0001, 32'($urandom)};
		foreach (masks[i]) begin
			write_mask(masks[i]);
			send_random_events(40);
		end
	endtask

	// Long random phases; idling on each side is switched per phase so that
	// some phases run without gaps.
	task automatic test_random_votes();
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 5)
				write_mask(bvva_pkg::MASK_RESET);
			else
				write_mask(bvva_pkg::MASK_W'($urandom));
			sender_gaps = (phase % 3 != 2) && $urandom_range(0, 3) != 0;
			sink_stalls = (phase % 3 != 2) && $urandom_range(0, 3) != 0;
			send_random_events(150);
		end
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
	endtask

	// The sender holds off until every result is back, several times over.
	task automatic test_drain_pause();
		repeat (5) begin
			send_random_events(5);
			wait_drained();
		end
	endtask

	// Last part: no idling on either side.
	task automatic test_back_to_back();
		sender_gaps = 1'b0;
		sink_stalls = 1'b0;
		write_mask(bvva_pkg::MASK_W'($urandom));
		send_random_events(200);
	endtask

	// Result checking: every result transfer is matched against the oldest
	// expected totals.
	always @(posedge clk) begin
		vote_totals_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_totals.size() == 0) begin
				report_mismatch("result with nothing pending", res_ch.total_bandwidth, 0);
			end else begin
				want = pending_totals.pop_front();
				results_checked++;
				if (want.status == bvva_pkg::ST_MISSING)
					missing_seen++;
				if (want.changed)
					changed_seen++;
				if (res_ch.status !== want.status)
					report_mismatch("status", res_ch.status, want.status);
				if (res_ch.vote_changed !== want.changed)
					report_mismatch("vote_changed", res_ch.vote_changed, want.changed);
				if (res_ch.total_voltage !== want.volt)
					report_mismatch("total_voltage", res_ch.total_voltage, want.volt);
				if (res_ch.total_bandwidth !== want.bw)
					report_mismatch("total_bandwidth", res_ch.total_bandwidth, want.bw);
			end
		end
	end

	// Result side: ready drops in random bursts while stalls are enabled.
	initial begin
		int unsigned hold_left;
		hold_left    = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && sink_stalls && $urandom_range(0, 5) == 0)
				hold_left = $urandom_range(1, 15);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: counts cycles without any transfer on any channel.
	always @(posedge clk) begin
		if (!arst_n || (ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
			$time, WATCHDOG_LIMIT, pending_totals.size());
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n                 <= 1'b0;
		ev_ch.valid            <= 1'b0;
		ev_ch.resource_index   <= '0;
		ev_ch.resource_present <= 1'b0;
		ev_ch.resource_state   <= bvva_pkg::RS_RELEASED;
		ev_ch.max_bandwidth    <= '0;
		ev_ch.needed_bandwidth <= '0;
		ev_ch.floor_level      <= '0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.data            <= '0;
		quiet_cycles = 0;
		err_count = 0;
		printed_count = 0;
		events_sent = 0;
		results_checked = 0;
		missing_seen = 0;
		changed_seen = 0;
		mask_writes = 0;
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;

		// The block comes out of reset with an empty store and the default mask.
		for (int i = 0; i < bvva_pkg::NUM_RES; i++) begin
			bw_vote[i]   = '0;
			volt_vote[i] = '0;
		end
		agg_volt      = '0;
		agg_bw        = '0;
		producer_bits = bvva_pkg::MASK_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_mask_sweep();
		test_random_votes();
		test_drain_pause();
		test_back_to_back();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_totals.size() != 0)
			report_mismatch("results never returned", 0, pending_totals.size());

		$display("Covered %0d events (%0d for missing resources), %0d results checked,",
			events_sent, missing_seen, results_checked);
		$display("%0d aggregate changes, %0d producer mask writes, %0d mismatches.",
			changed_seen, mask_writes, err_count);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
